@@ rtl/core/ntg_pkg.sv @@
// Shared types, constants and the tanh table for the NARMA target generator.
`default_nettype none

package ntg_pkg;

   localparam int SAMPLE_W  = 16;  // Q1.15 input sample
   localparam int TARGET_W  = 16;  // Q2.14 output
   localparam int ORDER_W   = 6;
   localparam int SEEN_W    = 6;
   localparam int WS_W      = 22;  // running window sum, Q8.14
   localparam int ACC_W     = 49;  // Q44 accumulator
   localparam int MUL_A_W   = 38;
   localparam int MUL_B_W   = 18;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int TANH_W    = 15;
   localparam int FRAC_W    = 42;  // tanh table step is 0.25 in Q44
   localparam int HALF_W    = FRAC_W / 2;
   localparam int IDX_W     = 5;
   localparam int ROUND_SH  = 30;  // Q44 down to Q14

   localparam logic [ORDER_W-1:0] ORDER_RESET   = 6'd10;
   localparam int                 ORDER_MIN     = 5;
   localparam int                 ORDER_LIN_MAX = 10;
   localparam logic [SEEN_W-1:0]  SEEN_MAX      = 6'd63;

   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 16'h8000;

   localparam logic signed [MUL_B_W-1:0] ALPHA_Q16 = 18'sd19661;  // 0.3
   localparam logic signed [MUL_B_W-1:0] BETA_Q16  = 18'sd3277;   // 0.05

   localparam logic signed [ACC_W-1:0] DELTA_LO = 49'sd1759218604442;   // 0.1
   localparam logic signed [ACC_W-1:0] DELTA_HI = 49'sd175921860444;    // 0.01
   localparam logic signed [ACC_W-1:0] ONE_Q44  = 49'sd17592186044416;
   localparam logic signed [ACC_W-1:0] HALF_Q30 = 49'sd536870912;

   localparam logic [ACC_W-1:0]  TANH_SAT = 49'd87960930222080;  // 5.0 in Q44
   localparam logic [TANH_W-1:0] TANH_TOP = 15'd16383;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALPHA,
      ST_CROSS,
      ST_BETA,
      ST_INPUT,
      ST_SUM,
      ST_ROUND,
      ST_TANH_HI,
      ST_TANH_LO,
      ST_TANH_OUT,
      ST_WRITE
   } ntg_state_type;

   // tanh at steps of 0.25 over [0,5], Q14
   function automatic logic [TANH_W-1:0] tanh_lut(input logic [IDX_W:0] idx);
      logic [TANH_W-1:0] val;
      case (idx)
         6'd0:    val = 15'd0;
         6'd1:    val = 15'd4013;
         6'd2:    val = 15'd7571;
         6'd3:    val = 15'd10406;
         6'd4:    val = 15'd12478;
         6'd5:    val = 15'd13898;
         6'd6:    val = 15'd14830;
         6'd7:    val = 15'd15423;
         6'd8:    val = 15'd15795;
         6'd9:    val = 15'd16024;
         6'd10:   val = 15'd16165;
         6'd11:   val = 15'd16251;
         6'd12:   val = 15'd16303;
         6'd13:   val = 15'd16335;
         6'd14:   val = 15'd16354;
         6'd15:   val = 15'd16366;
         6'd16:   val = 15'd16373;
         6'd17:   val = 15'd16377;
         6'd18:   val = 15'd16380;
         6'd19:   val = 15'd16382;
         default: val = TANH_TOP;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ntg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ntg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/narma_target_generator.sv @@
// Top level of the NARMA target generator: sequencer, shared multiplier and history RAM.
//
// Streaming NARMA system of order N (csr_system_order, saturated to [5, MAX_ORDER]).
// Each item on the req_ channel is a Q1.15 sample; each produces exactly one
// rsp_ item: target_out in Q2.14 clamped to [-1,1], and warmed_up, which is set
// once N earlier samples have been seen (before that target_out is 0). For
// N <= 10 the recurrence is clamped and rounded; for N >= 11 it passes through a
// piecewise-linear tanh. All products go through one 38x18 signed multiplier
// stepped by a small sequencer, so the block takes the next item only after the
// last one leaves the write state; warm-up items go straight there, the tanh
// path adds states, and a stalled result register holds the item there. req_stall
// stays high while an item is in work. The output and input histories share one
// RAM of MAX_ORDER entries; entries not yet written since reset are never read,
// since the delayed tap only comes into use after warm-up, so no clearing pass
// is needed. Writing csr_system_order (taken only while idle) restarts warm-up.
`default_nettype none

module narma_target_generator #(
   parameter int MAX_ORDER = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input items
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [ntg_pkg::SAMPLE_W-1:0] req_sample_in,
   // result items
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [ntg_pkg::TARGET_W-1:0]      rsp_target_out,
   output logic                                     rsp_warmed_up,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ntg_pkg::ORDER_W-1:0]         csr_system_order
);

   import ntg_pkg::*;

   localparam int AW     = $clog2(MAX_ORDER);
   localparam int NW_RAW = $clog2(MAX_ORDER + 1);
   localparam int OW     = (NW_RAW > ORDER_W) ? NW_RAW : ORDER_W;
   localparam int RAM_W  = TARGET_W + SAMPLE_W;

   // sequencer
   ntg_state_type state_ff, state_in;

   // stream state
   logic [ORDER_W-1:0]         order_ff, order_in;
   logic signed [WS_W-1:0]     ws_ff, ws_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [SEEN_W-1:0]          seen_ff, seen_in;
   logic signed [TARGET_W-1:0] last_y_ff, last_y_in;

   // per-item datapath
   logic [SAMPLE_W-1:0]        ucur_ff, ucur_in;
   logic                       warm_ff, warm_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [PROD_W-1:0]          tsum_ff, tsum_in;
   logic signed [TARGET_W-1:0] y_ff, y_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [TARGET_W-1:0] rsp_target_ff, rsp_target_in;
   logic                       rsp_warm_ff, rsp_warm_in;

   // control
   logic                       req_take;
   logic                       csr_take;
   logic                       out_free;
   logic                       retire;
   logic [OW-1:0]              order_ext;
   logic [OW-1:0]              order_n;
   logic                       warm_now;
   logic                       use_tanh;
   logic [OW-1:0]              wp_ext;
   logic [OW-1:0]              old_pos;

   // shared multiplier
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;

   // history RAM
   logic                       ram_wr_en;
   logic [RAM_W-1:0]           ram_wr_data;
   logic                       ram_rd_en;
   logic [RAM_W-1:0]           ram_rd_data;
   logic signed [TARGET_W-1:0] old_y;
   logic [SAMPLE_W-1:0]        old_u;

   // datapath helpers
   logic signed [ACC_W-1:0]    prod_acc;
   logic signed [ACC_W-1:0]    clamp_v;
   logic signed [ACC_W-1:0]    lin_v;
   logic [IDX_W-1:0]           tanh_idx;
   logic [TANH_W-1:0]          tanh_base;
   logic [TANH_W-1:0]          tanh_diff;
   logic [PROD_W-1:0]          tanh_total;
   logic [TANH_W-1:0]          tanh_mag;

   //------------------------------------------------------------------------
   // Order, warm-up and ring positions
   //------------------------------------------------------------------------
   always_comb begin
      order_ext = OW'(order_ff);
      if (order_ext < OW'(ORDER_MIN)) begin
         order_n = OW'(ORDER_MIN);
      end else if (order_ext > OW'(MAX_ORDER)) begin
         order_n = OW'(MAX_ORDER);
      end else begin
         order_n = order_ext;
      end
   end

   assign warm_now = OW'(seen_ff) >= order_n;
   assign use_tanh = order_n > OW'(ORDER_LIN_MAX);
   assign wp_ext   = OW'(wp_ff);

   // slot written N items ago
   always_comb begin
      if (wp_ext >= order_n) begin
         old_pos = wp_ext - order_n;
      end else begin
         old_pos = wp_ext + OW'(MAX_ORDER) - order_n;
      end
   end

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign retire   = (state_ff == ST_WRITE) && out_free;

   //------------------------------------------------------------------------
   // Next state
   //------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = warm_now ? ST_ALPHA : ST_WRITE;
            end
         end
         ST_ALPHA:    state_in = ST_CROSS;
         ST_CROSS:    state_in = ST_BETA;
         ST_BETA:     state_in = ST_INPUT;
         ST_INPUT:    state_in = ST_SUM;
         ST_SUM:      state_in = ST_ROUND;
         ST_ROUND:    state_in = use_tanh ? ST_TANH_HI : ST_WRITE;
         ST_TANH_HI:  state_in = ST_TANH_LO;
         ST_TANH_LO:  state_in = ST_TANH_OUT;
         ST_TANH_OUT: state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   //------------------------------------------------------------------------
   // Sequencer outputs: handshakes, RAM strobes, multiplier operands
   //------------------------------------------------------------------------
   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // config has priority over a sample in the same cycle
            csr_ready = 1'b1;
            req_stall = csr_valid;
            ram_rd_en = req_take && warm_now;
         end
         ST_ALPHA: begin
            // y[t-1] * 0.3
            mul_a = {{(MUL_A_W-TARGET_W){last_y_ff[TARGET_W-1]}}, last_y_ff};
            mul_b = ALPHA_Q16;
         end
         ST_CROSS: begin
            // y[t-1] * window sum
            mul_a = {{(MUL_A_W-WS_W){ws_ff[WS_W-1]}}, ws_ff};
            mul_b = {{(MUL_B_W-TARGET_W){last_y_ff[TARGET_W-1]}}, last_y_ff};
         end
         ST_BETA: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = BETA_Q16;
         end
         ST_INPUT: begin
            // u'[t-N] * u'[t], both unsigned
            mul_a = {{(MUL_A_W-SAMPLE_W){1'b0}}, old_u};
            mul_b = {{(MUL_B_W-SAMPLE_W){1'b0}}, ucur_ff};
         end
         ST_TANH_HI: begin
            mul_a = {{(MUL_A_W-HALF_W){1'b0}}, mag_ff[FRAC_W-1:HALF_W]};
            mul_b = {{(MUL_B_W-TANH_W){1'b0}}, tanh_diff};
         end
         ST_TANH_LO: begin
            mul_a = {{(MUL_A_W-HALF_W){1'b0}}, mag_ff[HALF_W-1:0]};
            mul_b = {{(MUL_B_W-TANH_W){1'b0}}, tanh_diff};
         end
         ST_WRITE: begin
            ram_wr_en = out_free;
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   //------------------------------------------------------------------------
   // Datapath
   //------------------------------------------------------------------------
   assign old_y    = ram_rd_data[RAM_W-1:SAMPLE_W];
   assign old_u    = ram_rd_data[SAMPLE_W-1:0];
   assign prod_acc = prod_ff[ACC_W-1:0];

   // linear path: clamp to [-1,1], round half up to Q14
   always_comb begin
      if (acc_ff > ONE_Q44) begin
         clamp_v = ONE_Q44;
      end else if (acc_ff < -ONE_Q44) begin
         clamp_v = -ONE_Q44;
      end else begin
         clamp_v = acc_ff;
      end
      lin_v = (clamp_v + HALF_Q30) >>> ROUND_SH;
   end

   // tanh path: table base plus interpolated fraction
   assign tanh_idx   = mag_ff[FRAC_W+IDX_W-1:FRAC_W];
   assign tanh_base  = tanh_lut({1'b0, tanh_idx});
   assign tanh_diff  = tanh_lut({1'b0, tanh_idx} + 1'b1) - tanh_base;
   assign tanh_total = tsum_ff + PROD_W'(prod_ff) + (PROD_W'(1) << (FRAC_W - 1));

   always_comb begin
      if (mag_ff >= TANH_SAT) begin
         tanh_mag = TANH_TOP;
      end else begin
         tanh_mag = tanh_base + TANH_W'(tanh_total[PROD_W-1:FRAC_W]);
      end
   end

   always_comb begin
      ucur_in   = ucur_ff;
      warm_in   = warm_ff;
      prod_in   = mul_p;
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      tsum_in   = tsum_ff;
      y_in      = y_ff;
      order_in  = order_ff;
      ws_in     = ws_ff;
      wp_in     = wp_ff;
      seen_in   = seen_ff;
      last_y_in = last_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_take) begin
               order_in  = csr_system_order;
               ws_in     = '0;
               wp_in     = '0;
               seen_in   = '0;
               last_y_in = '0;
            end else if (req_take) begin
               ucur_in = req_sample_in ^ SIGN_FLIP;
               warm_in = warm_now;
               y_in    = '0;
            end
         end
         ST_CROSS: begin
            acc_in = (prod_acc <<< 14) + (use_tanh ? DELTA_HI : DELTA_LO);
         end
         ST_INPUT: begin
            acc_in = acc_ff + prod_acc;
         end
         ST_SUM: begin
            // 1.5 * u'u' in Q44 is 3 * product << 9
            acc_in = acc_ff + ((prod_acc + (prod_acc <<< 1)) <<< 9);
         end
         ST_ROUND: begin
            y_in   = lin_v[TARGET_W-1:0];
            neg_in = acc_ff[ACC_W-1];
            mag_in = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         end
         ST_TANH_LO: begin
            tsum_in = PROD_W'(prod_ff) << HALF_W;
         end
         ST_TANH_OUT: begin
            y_in = neg_ff ? -$signed({1'b0, tanh_mag}) : $signed({1'b0, tanh_mag});
         end
         ST_WRITE: begin
            if (out_free) begin
               ws_in = ws_ff + WS_W'(y_ff) - (warm_ff ? WS_W'(old_y) : WS_W'(0));
               wp_in = (wp_ff == AW'(MAX_ORDER - 1)) ? '0 : wp_ff + 1'b1;
               if (seen_ff != SEEN_MAX) begin
                  seen_in = seen_ff + 1'b1;
               end
               last_y_in = y_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_wr_data = {y_ff, ucur_ff};

   // result register loads when the item retires
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_target_in = rsp_target_ff;
      rsp_warm_in   = rsp_warm_ff;
      if (retire) begin
         rsp_valid_in  = 1'b1;
         rsp_target_in = y_ff;
         rsp_warm_in   = warm_ff;
      end
   end

   //------------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= ORDER_RESET;
         ws_ff        <= '0;
         wp_ff        <= '0;
         seen_ff      <= '0;
         last_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         ws_ff        <= ws_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         last_y_ff    <= last_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ucur_ff       <= ucur_in;
      warm_ff       <= warm_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      tsum_ff       <= tsum_in;
      y_ff          <= y_in;
      rsp_target_ff <= rsp_target_in;
      rsp_warm_ff   <= rsp_warm_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_target_out = rsp_target_ff;
   assign rsp_warmed_up  = rsp_warm_ff;

   //------------------------------------------------------------------------
   // History RAM: {output, scaled input} per slot
   //------------------------------------------------------------------------
   ntg_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_ORDER)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (old_pos[AW-1:0]),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

@@ tb/sv/ntg_tb_pkg.sv @@
// Tracker class: NARMA target prediction and result checking for the testbench.
`timescale 1ns / 1ps

package ntg_tb_pkg;

   import ntg_pkg::SAMPLE_W;
   import ntg_pkg::TARGET_W;
   import ntg_pkg::ORDER_W;

   localparam int HIST_DEPTH = 32;
   localparam int LOW_ORDER  = 5;
   localparam int LIN_ORDER  = 10;
   localparam int SEEN_TOP   = 63;
   localparam int ORDER_INIT = 10;

   localparam longint ALPHA_Q16  = 19661;
   localparam longint BETA_Q16   = 3277;
   localparam longint DELTA_LO   = 64'sd1759218604442;
   localparam longint DELTA_HI   = 64'sd175921860444;
   localparam longint UNITY_Q44  = 64'sd17592186044416;
   localparam int     KNEE_STEPS = 20;

   typedef struct packed {
      logic signed [TARGET_W-1:0] target_out;
      logic                       warmed_up;
   } narma_result_type;

   class narma_tracker;
      logic [ORDER_W-1:0] order_reg;
      int                 out_hist [HIST_DEPTH];
      int unsigned        in_hist [HIST_DEPTH];
      int                 win_sum;
      int unsigned        wpos;
      int unsigned        seen;
      int                 knee [KNEE_STEPS+1];
      narma_result_type   pending_targets [$];
      int                 mismatches;

      function new();
         knee = '{0, 4013, 7571, 10406, 12478, 13898, 14830, 15423, 15795, 16024,
                  16165, 16251, 16303, 16335, 16354, 16366, 16373, 16377, 16380,
                  16382, 16383};
         order_reg  = ORDER_W'(ORDER_INIT);
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         foreach (out_hist[i]) out_hist[i] = 0;
         foreach (in_hist[i]) in_hist[i] = 0;
         win_sum = 0;
         wpos    = 0;
         seen    = 0;
      endfunction

      // a write also clears the stream
      function void set_order(logic [ORDER_W-1:0] val);
         order_reg = val;
         restart();
      endfunction

      function int unsigned live_order();
         if (order_reg < LOW_ORDER) return LOW_ORDER;
         if (order_reg > HIST_DEPTH) return HIST_DEPTH;
         return order_reg;
      endfunction

      // piecewise-linear tanh, Q44 in, Q14 out
      function int squash(longint v);
         bit                neg;
         longint unsigned   mag;
         longint unsigned   frac;
         longint unsigned   diff;
         int                idx;
         int                r;
         neg = v < 0;
         mag = neg ? longint'(-v) : v;
         if (mag >= (64'd20 << 42)) begin
            r = knee[KNEE_STEPS];
         end else begin
            idx  = int'(mag >> 42);
            frac = mag & 64'h3FF_FFFF_FFFF;
            diff = knee[idx+1] - knee[idx];
            r    = knee[idx] + int'((diff * frac + (64'd1 << 41)) >> 42);
         end
         return neg ? -r : r;
      endfunction

      function int clip_round(longint v);
         longint b;
         if (v > UNITY_Q44) v = UNITY_Q44;
         if (v < -UNITY_Q44) v = -UNITY_Q44;
         b = v + UNITY_Q44 + (64'sd1 << 29);
         return int'(b >>> 30) - 16384;
      endfunction

      function void take_sample(logic signed [SAMPLE_W-1:0] s);
         int unsigned      n;
         int unsigned      ucur;
         int unsigned      old_pos;
         int               y1;
         int               y;
         longint           acc;
         narma_result_type res;
         n       = live_order();
         ucur    = {~s[SAMPLE_W-1], s[SAMPLE_W-2:0]};
         old_pos = (wpos + HIST_DEPTH - n) % HIST_DEPTH;
         y       = 0;
         res.warmed_up = 1'b0;
         if (seen >= n) begin
            y1  = out_hist[(wpos + HIST_DEPTH - 1) % HIST_DEPTH];
            acc = longint'(y1) * ALPHA_Q16 * 16384
                + longint'(y1) * longint'(win_sum) * BETA_Q16
                + ((longint'(in_hist[old_pos]) * longint'(ucur) * 3) << 9);
            if (n > LIN_ORDER) y = squash(acc + DELTA_HI);
            else y = clip_round(acc + DELTA_LO);
            res.warmed_up = 1'b1;
         end
         win_sum = win_sum + y - out_hist[old_pos];
         out_hist[wpos] = y;
         in_hist[wpos]  = ucur;
         wpos = (wpos + 1) % HIST_DEPTH;
         if (seen < SEEN_TOP) seen++;
         res.target_out = y[TARGET_W-1:0];
         pending_targets = {pending_targets, res};
      endfunction

      function void match_result(logic signed [TARGET_W-1:0] target_out, logic warmed_up);
         narma_result_type want;
         if (pending_targets.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected item target_out=%0d warmed_up=%0b",
                        $realtime, target_out, warmed_up);
            return;
         end
         want = pending_targets.pop_front();
         if (want.target_out !== target_out || want.warmed_up !== warmed_up) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch target_out exp %0d got %0d, warmed_up exp %0b got %0b",
                        $realtime, want.target_out, target_out, want.warmed_up, warmed_up);
         end
      endfunction

      function int pending();
         return pending_targets.size();
      endfunction
   endclass

endpackage

@@ tb/sv/tb_narma_target_generator.sv @@
// Top-level testbench for narma_target_generator: stimulus, handshakes and checking.
`timescale 1ns / 1ps

module tb_narma_target_generator;

   import ntg_pkg::SAMPLE_W;
   import ntg_pkg::TARGET_W;
   import ntg_pkg::ORDER_W;
   import ntg_tb_pkg::*;

   localparam int PHASES      = 8;
   localparam int DRAIN_WAIT  = 24;   // covers the slowest item, on the tanh path, with margin on top
   localparam int LONG_HOLD   = 120;  // receiver hold-off, well past the block's depth

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [TARGET_W-1:0] rsp_target_out;
   logic                       rsp_warmed_up;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [ORDER_W-1:0]         csr_system_order;

   // idling knobs, written by the main sequence only
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_armed;

   // owned by the receiver process
   bit hold_used;
   int hold_count;

   narma_tracker tracker;

   narma_target_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_target_out   (rsp_target_out),
      .rsp_warmed_up    (rsp_warmed_up),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_system_order (csr_system_order)
   );

   always #10 clock = ~clock;

   // Receiver: random stall per cycle, plus one long hold-off that backs the
   // block up until it stalls its input.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_used) begin
         hold_used  = 1'b1;
         hold_count = LONG_HOLD - 1;
         rsp_stall  <= 1'b1;
      end else if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Every accepted result goes straight to the checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.match_result(rsp_target_out, rsp_warmed_up);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid is only lowered for an idle gap, never lowered and raised in one step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(s);
      @(negedge clock);
   endtask

   task automatic write_order(input logic [ORDER_W-1:0] val);
      csr_valid        <= 1'b1;
      csr_system_order <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.set_order(val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every expected item, then let the sequencer finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly uniform samples, with the rails and the top of the range favored
   // so the linear path clamps and the tanh path sees large arguments.
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9)) inside
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         [2:3]:   return 16'sh7000 | SAMPLE_W'($urandom_range(0, 16'h0FFF));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   initial begin : main_seq
      logic signed [SAMPLE_W-1:0] corner [24];
      logic [ORDER_W-1:0]         orders [PHASES];
      int                         count;

      corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
                 16'shAAAA, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
                 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
                 16'sh0000, 16'sh7FFF, 16'shFFFF, 16'sh7FFF, 16'sh8001, 16'sh7FFE};
      // short order, both out-of-range ends, both sides of the tanh switch,
      // the longest window, back to default, then random
      orders = '{6'd5, 6'd0, 6'd63, 6'd11, 6'd32, 6'd10,
                 ORDER_W'($urandom_range(0, 63)), ORDER_W'($urandom_range(5, 32))};

      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      rsp_stall        = 1'b0;
      csr_valid        = 1'b0;
      csr_system_order = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_armed       = 1'b0;
      hold_used        = 1'b0;
      hold_count       = 0;
      tracker          = new();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset order of 10, warm-up, then rails to drive the clamp
      foreach (corner[i]) send_sample(corner[i]);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_order(orders[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         // long hold-off in a phase where the sender never pauses
         if (p == 4) hold_armed = 1'b1;
         // over 63 items per phase so the seen counter saturates
         count = $urandom_range(75, 95);
         repeat (count) send_sample(pick_sample());
      end

      settle();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
